// File: hw/rtl/linked_list_pool_manager_defines.svh
// Assertion macros for the linked list pool manager checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef LINKED_LIST_POOL_MANAGER_DEFINES_SVH
`define LINKED_LIST_POOL_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLPM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("llpm check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LLPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("llpm check failed");

`endif

// File: hw/rtl/llpm_pkg.sv
// Shared types and codes of the linked list pool manager.
// No dependencies; used by every other file of the block but the defines header.
`timescale 1ns / 1ps
`default_nettype none

package llpm_pkg;

  typedef enum logic [3:0] {
    OP_CREATE  = 4'd0,
    OP_COUNT   = 4'd1,
    OP_FIRST   = 4'd2,
    OP_LAST    = 4'd3,
    OP_NEXT    = 4'd4,
    OP_PREV    = 4'd5,
    OP_CURRENT = 4'd6,
    OP_ADD     = 4'd7,
    OP_INSERT  = 4'd8,
    OP_APPEND  = 4'd9,
    OP_PREPEND = 4'd10,
    OP_REMOVE  = 4'd11,
    OP_CONCAT  = 4'd12,
    OP_FREE    = 4'd13,
    OP_TRIM    = 4'd14,
    OP_SEARCH  = 4'd15
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NO_NODE   = 2'd2,
    ST_NO_HEAD   = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]  mode;
    logic [3:0]  list_id;
    logic [3:0]  second_list_id;
    logic [31:0] item_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        item_valid;
    logic [31:0] item_out;
    logic [3:0]  new_list_id;
    logic [8:0]  list_length;
  } out_t;

  // Per-field write enables of the node memory.
  typedef struct packed {
    logic item;
    logic nxt;
    logic prv;
    logic flink;
  } node_field_mask_t;

endpackage

`default_nettype wire

// File: hw/rtl/llpm_node_ram.sv
// Node memory of the pool: item, forward link, backward link and free link.
// One write and one registered read per cycle; depends on llpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module llpm_node_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int PW    = 9,
  parameter int IW    = 32
) (
  input  wire logic                        clk_i,
  input  wire logic [AW-1:0]               rd_addr_i,
  output logic      [IW-1:0]               rd_item_o,
  output logic      [PW-1:0]               rd_next_o,
  output logic      [PW-1:0]               rd_prev_o,
  output logic      [PW-1:0]               rd_flink_o,
  input  wire llpm_pkg::node_field_mask_t  wr_mask_i,
  input  wire logic [AW-1:0]               wr_addr_i,
  input  wire logic [IW-1:0]               wr_item_i,
  input  wire logic [PW-1:0]               wr_next_i,
  input  wire logic [PW-1:0]               wr_prev_i,
  input  wire logic [PW-1:0]               wr_flink_i
);
  import llpm_pkg::*;

  logic [IW-1:0] mem_item  [DEPTH];
  logic [PW-1:0] mem_next  [DEPTH];
  logic [PW-1:0] mem_prev  [DEPTH];
  logic [PW-1:0] mem_flink [DEPTH];
  logic          same_addr;

  assign same_addr = (rd_addr_i == wr_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_mask_i.item)  mem_item[wr_addr_i]  <= wr_item_i;
    if (wr_mask_i.nxt)   mem_next[wr_addr_i]  <= wr_next_i;
    if (wr_mask_i.prv)   mem_prev[wr_addr_i]  <= wr_prev_i;
    if (wr_mask_i.flink) mem_flink[wr_addr_i] <= wr_flink_i;
  end

  // A read of the entry being written returns the new value.
  always_ff @(posedge clk_i) begin
    rd_item_o  <= (same_addr && wr_mask_i.item)  ? wr_item_i  : mem_item[rd_addr_i];
    rd_next_o  <= (same_addr && wr_mask_i.nxt)   ? wr_next_i  : mem_next[rd_addr_i];
    rd_prev_o  <= (same_addr && wr_mask_i.prv)   ? wr_prev_i  : mem_prev[rd_addr_i];
    rd_flink_o <= (same_addr && wr_mask_i.flink) ? wr_flink_i : mem_flink[rd_addr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/linked_list_pool_manager.sv
// Top level of the linked list pool manager: sequencer, list head table and stacks.
// Depends on llpm_pkg and llpm_node_ram.
//
// Usage. Requests arrive on the input channel (in_valid_i, in_stall_o, in_data_i) and
// each one produces exactly one response on the output channel (out_valid_o,
// out_stall_i, out_data_o). A transfer takes place on a rising edge where valid is high
// and stall is low. The block works on one request at a time: in_stall_o stays high
// from the transfer of a request until its response has been loaded into the output
// register, so the next request may be taken while that response still waits.
// A new request is taken only once the response to the last one has been loaded. Free
// and search walk the list one node per step, since each step waits on one read of the
// node memory. The node memory has a single read and a single write port and every link
// update goes through it.
// Reset clears the head table, both free stacks and the counters at once; no clearing
// pass is needed and a request can be taken as soon as reset is released.
// While the receiver stalls, the response holds steady in the output register.
`timescale 1ns / 1ps
`default_nettype none

module linked_list_pool_manager #(
  parameter int NUM_NODES  = 256,
  parameter int NUM_LISTS  = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire llpm_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output llpm_pkg::out_t     out_data_o
);
  import llpm_pkg::*;

  // Node references carry one extra code, NUM_NODES, that stands for no node.
  localparam int NIW = $clog2(NUM_NODES);
  localparam int NW  = $clog2(NUM_NODES + 1);
  localparam int LIW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int LW  = $clog2(NUM_LISTS + 1);
  localparam int IW  = ITEM_WIDTH;

  localparam logic [NW-1:0] NNULL = NW'(NUM_NODES);
  localparam logic [LW-1:0] HNULL = LW'(NUM_LISTS);

  typedef struct packed {
    logic [NW-1:0] hd;
    logic [NW-1:0] tl;
    logic [NW-1:0] cur;
    logic [NW-1:0] len;
    logic          bs;
    logic          be;
  } head_rec_t;

  localparam head_rec_t HEAD_CLR = '{hd: NNULL, tl: NNULL, cur: NNULL, len: '0,
                                     bs: 1'b0, be: 1'b0};

  // One pending write to the node memory.
  typedef struct packed {
    logic             v;
    node_field_mask_t m;
    logic [NIW-1:0]   a;
    logic [IW-1:0]    item;
    logic [NW-1:0]    nx;
    logic [NW-1:0]    pv;
    logic [NW-1:0]    fl;
  } slot_t;

  typedef enum logic [1:0] {
    LK_FIRST,
    LK_LAST,
    LK_AFTER,
    LK_BEFORE
  } link_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_LINK,
    S_STEP,
    S_RDITEM,
    S_UNLINK,
    S_CAT,
    S_FREE,
    S_SEARCH,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e            state_q, state_d;
  mode_e             op_q, op_d;
  logic [3:0]        l_q, l_d, s_q, s_d;
  logic [IW-1:0]     val_q, val_d;
  head_rec_t         w_q, w_d;
  link_e             cat_q, cat_d;
  logic [NW-1:0]     x_q, x_d, cnt_q, cnt_d, n_q, n_d;
  logic [1:0]        status_q, status_d;
  logic              ivalid_q, ivalid_d, wb_q, wb_d;
  logic [IW-1:0]     item_q, item_d;
  logic [3:0]        newid_q, newid_d;
  slot_t             slot_q [3];
  slot_t             slot_d [3];
  logic [1:0]        dptr_q, dptr_d;
  logic [NW-1:0]     ntop_q, ntop_d, hwm_q, hwm_d, nodes_q, nodes_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  // List head table and free head stack.
  head_rec_t         heads_q [NUM_LISTS];
  logic [NUM_LISTS-1:0] inuse_q;
  logic [LW-1:0]     hflink_q [NUM_LISTS];
  logic [LW-1:0]     htop_q, hcnt_q;

  logic              cr_en, rel_en, wb_en;
  logic [LIW-1:0]    rel_id;

  logic [3:0]        hsel;
  head_rec_t         hrec;
  logic              l_ok, s_ok;

  logic [NIW-1:0]    rd_addr;
  logic [IW-1:0]     rd_item;
  logic [NW-1:0]     rd_next, rd_prev, rd_flink;
  node_field_mask_t  wr_mask;
  logic [NIW-1:0]    wr_addr;
  logic [IW-1:0]     wr_item;
  logic [NW-1:0]     wr_next, wr_prev, wr_flink;

  llpm_node_ram #(
    .DEPTH (NUM_NODES),
    .AW    (NIW),
    .PW    (NW),
    .IW    (IW)
  ) u_ram (
    .clk_i      (clk_i),
    .rd_addr_i  (rd_addr),
    .rd_item_o  (rd_item),
    .rd_next_o  (rd_next),
    .rd_prev_o  (rd_prev),
    .rd_flink_o (rd_flink),
    .wr_mask_i  (wr_mask),
    .wr_addr_i  (wr_addr),
    .wr_item_i  (wr_item),
    .wr_next_i  (wr_next),
    .wr_prev_i  (wr_prev),
    .wr_flink_i (wr_flink)
  );

  // The head table is read at one list per cycle: the source list while
  // a concatenation takes it over, the addressed list otherwise.
  assign hsel = (state_q == S_CAT) ? s_q : l_q;
  assign hrec = heads_q[LIW'(hsel)];
  assign l_ok = (32'(l_q) < NUM_LISTS) && inuse_q[LIW'(l_q)];
  assign s_ok = (32'(s_q) < NUM_LISTS) && inuse_q[LIW'(s_q)] && (s_q != l_q);

  // Node memory write port: the free walk writes directly, the other
  // operations drain their queued writes one per cycle.
  always_comb begin
    wr_mask  = '0;
    wr_addr  = '0;
    wr_item  = slot_q[dptr_q].item;
    wr_next  = slot_q[dptr_q].nx;
    wr_prev  = slot_q[dptr_q].pv;
    wr_flink = slot_q[dptr_q].fl;
    if (state_q == S_FREE) begin
      wr_mask.flink = 1'b1;
      wr_addr       = x_q[NIW-1:0];
      wr_flink      = ntop_q;
    end else if (state_q == S_DRAIN && slot_q[dptr_q].v) begin
      wr_mask = slot_q[dptr_q].m;
      wr_addr = slot_q[dptr_q].a;
    end
  end

  always_comb begin
    logic [NW-1:0] c;
    logic [NW-1:0] nc;
    logic [NW-1:0] p;
    logic [NW-1:0] nlen;
    head_rec_t     wt;

    state_d     = state_q;
    op_d        = op_q;
    l_d         = l_q;
    s_d         = s_q;
    val_d       = val_q;
    w_d         = w_q;
    cat_d       = cat_q;
    x_d         = x_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    status_d    = status_q;
    ivalid_d    = ivalid_q;
    wb_d        = wb_q;
    item_d      = item_q;
    newid_d     = newid_q;
    slot_d      = slot_q;
    dptr_d      = dptr_q;
    ntop_d      = ntop_q;
    hwm_d       = hwm_q;
    nodes_d     = nodes_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cr_en       = 1'b0;
    rel_en      = 1'b0;
    rel_id      = LIW'(l_q);
    wb_en       = 1'b0;
    rd_addr     = '0;
    c           = w_q.cur;
    nc          = NNULL;
    p           = NNULL;
    nlen        = '0;
    wt          = w_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = mode_e'(in_data_i.mode);
          l_d      = in_data_i.list_id;
          s_d      = in_data_i.second_list_id;
          val_d    = IW'(in_data_i.item_value);
          status_d = ST_OK;
          ivalid_d = 1'b0;
          item_d   = '0;
          newid_d  = '0;
          wb_d     = 1'b0;
          dptr_d   = '0;
          for (int i = 0; i < 3; i++) slot_d[i].v = 1'b0;
          state_d  = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        w_d     = hrec;
        c       = hrec.cur;
        state_d = S_FINISH;
        if (op_q == OP_CREATE) begin
          w_d = HEAD_CLR;
          if (hcnt_q >= LW'(NUM_LISTS) || htop_q == HNULL) begin
            status_d = ST_NO_HEAD;
          end else begin
            cr_en   = 1'b1;
            newid_d = 4'(htop_q);
          end
        end else if (!l_ok) begin
          w_d      = HEAD_CLR;
          status_d = ST_EMPTY;
        end else begin
          wb_d = 1'b1;
          case (op_q)
            OP_FIRST, OP_LAST: begin
              w_d.bs  = 1'b0;
              w_d.be  = 1'b0;
              w_d.cur = (op_q == OP_FIRST) ? hrec.hd : hrec.tl;
              if (hrec.len == '0 || w_d.cur == NNULL) begin
                w_d.cur  = NNULL;
                status_d = ST_EMPTY;
              end else begin
                rd_addr = w_d.cur[NIW-1:0];
                state_d = S_RDITEM;
              end
            end
            OP_NEXT, OP_PREV: begin
              if (hrec.len == '0) begin
                status_d = ST_EMPTY;
              end else if ((op_q == OP_NEXT) ? hrec.bs : hrec.be) begin
                // Stepping in from the mark lands on the end nearest to it.
                w_d.bs  = (op_q == OP_NEXT) ? 1'b0 : hrec.bs;
                w_d.be  = (op_q == OP_NEXT) ? hrec.be : 1'b0;
                w_d.cur = (op_q == OP_NEXT) ? hrec.hd : hrec.tl;
                if (w_d.cur == NNULL) begin
                  status_d = ST_EMPTY;
                end else begin
                  rd_addr = w_d.cur[NIW-1:0];
                  state_d = S_RDITEM;
                end
              end else if (((op_q == OP_NEXT) ? hrec.be : hrec.bs) ||
                           c == ((op_q == OP_NEXT) ? hrec.tl : hrec.hd) ||
                           c == NNULL) begin
                w_d.be   = (op_q == OP_NEXT) ? 1'b1 : hrec.be;
                w_d.bs   = (op_q == OP_NEXT) ? hrec.bs : 1'b1;
                w_d.cur  = NNULL;
                status_d = ST_EMPTY;
              end else begin
                rd_addr = c[NIW-1:0];
                state_d = S_STEP;
              end
            end
            OP_CURRENT: begin
              if (hrec.len == '0 || hrec.bs || hrec.be || c == NNULL) begin
                status_d = ST_EMPTY;
              end else begin
                rd_addr = c[NIW-1:0];
                state_d = S_RDITEM;
              end
            end
            OP_ADD, OP_INSERT, OP_APPEND, OP_PREPEND: begin
              if (nodes_q >= NW'(NUM_NODES) || ntop_q == NNULL) begin
                status_d = ST_NO_NODE;
              end else begin
                n_d     = ntop_q;
                rd_addr = ntop_q[NIW-1:0];
                state_d = S_POP;
                if (hrec.len == '0 || op_q == OP_PREPEND ||
                    (op_q == OP_ADD && hrec.bs) ||
                    (op_q == OP_INSERT && (hrec.bs || c == hrec.hd))) begin
                  cat_d = LK_FIRST;
                end else if (op_q == OP_APPEND || hrec.be || c == NNULL ||
                             (op_q == OP_ADD && c == hrec.tl)) begin
                  cat_d = LK_LAST;
                end else if (op_q == OP_ADD) begin
                  cat_d = LK_AFTER;
                end else begin
                  cat_d = LK_BEFORE;
                end
              end
            end
            OP_REMOVE: begin
              if (hrec.len == '0 || hrec.bs || hrec.be || c == NNULL) begin
                status_d = ST_EMPTY;
              end else begin
                x_d     = c;
                rd_addr = c[NIW-1:0];
                state_d = S_UNLINK;
              end
            end
            OP_TRIM: begin
              if (hrec.len == '0 || hrec.tl == NNULL) begin
                status_d = ST_EMPTY;
              end else begin
                x_d     = hrec.tl;
                rd_addr = hrec.tl[NIW-1:0];
                state_d = S_UNLINK;
              end
            end
            OP_CONCAT: begin
              if (!s_ok) begin
                status_d = ST_EMPTY;
              end else begin
                state_d = S_CAT;
              end
            end
            OP_FREE: begin
              if (hrec.len == '0 || hrec.hd == NNULL) begin
                rel_en = 1'b1;
                w_d    = HEAD_CLR;
              end else begin
                x_d     = hrec.hd;
                cnt_d   = '0;
                rd_addr = hrec.hd[NIW-1:0];
                state_d = S_FREE;
              end
            end
            OP_SEARCH: begin
              if (hrec.len == '0) begin
                status_d = ST_EMPTY;
              end else begin
                p = c;
                if (hrec.bs) begin
                  w_d.bs = 1'b0;
                  p      = hrec.hd;
                end else if (hrec.be) begin
                  p = NNULL;
                end
                if (p == NNULL) begin
                  w_d.cur  = NNULL;
                  w_d.be   = 1'b1;
                  status_d = ST_EMPTY;
                end else begin
                  x_d     = p;
                  rd_addr = p[NIW-1:0];
                  state_d = S_SEARCH;
                end
              end
            end
            default: begin
              // Count: nothing but the length is reported.
            end
          endcase
        end
      end

      S_POP: begin
        // Nodes above the high-water mark were never handed out, so their
        // free link is simply the next index.
        if (n_q == hwm_q) begin
          ntop_d = n_q + NW'(1);
          hwm_d  = hwm_q + NW'(1);
        end else begin
          ntop_d = rd_flink;
        end
        nodes_d = nodes_q + NW'(1);
        rd_addr = w_q.cur[NIW-1:0];
        state_d = S_LINK;
      end

      S_LINK: begin
        slot_d[0].v    = 1'b1;
        slot_d[0].m    = '{item: 1'b1, nxt: 1'b1, prv: 1'b1, flink: 1'b0};
        slot_d[0].a    = n_q[NIW-1:0];
        slot_d[0].item = val_q;
        slot_d[1].item = val_q;
        slot_d[2].item = val_q;
        slot_d[2].v    = 1'b0;
        case (cat_q)
          LK_FIRST: begin
            slot_d[0].pv = NNULL;
            slot_d[0].nx = w_q.hd;
            slot_d[1].v  = (w_q.hd != NNULL);
            slot_d[1].m  = '{item: 1'b0, nxt: 1'b0, prv: 1'b1, flink: 1'b0};
            slot_d[1].a  = w_q.hd[NIW-1:0];
            slot_d[1].pv = n_q;
            if (w_q.hd == NNULL) wt.tl = n_q;
            wt.hd = n_q;
            wt.bs = 1'b0;
            if (op_q != OP_ADD && op_q != OP_INSERT) wt.be = 1'b0;
          end
          LK_LAST: begin
            slot_d[0].nx = NNULL;
            slot_d[0].pv = w_q.tl;
            slot_d[1].v  = (w_q.tl != NNULL);
            slot_d[1].m  = '{item: 1'b0, nxt: 1'b1, prv: 1'b0, flink: 1'b0};
            slot_d[1].a  = w_q.tl[NIW-1:0];
            slot_d[1].nx = n_q;
            if (w_q.tl == NNULL) wt.hd = n_q;
            wt.tl = n_q;
            wt.bs = 1'b0;
            wt.be = 1'b0;
          end
          LK_AFTER: begin
            slot_d[0].pv = w_q.cur;
            slot_d[0].nx = rd_next;
            slot_d[1].v  = (rd_next != NNULL);
            slot_d[1].m  = '{item: 1'b0, nxt: 1'b0, prv: 1'b1, flink: 1'b0};
            slot_d[1].a  = rd_next[NIW-1:0];
            slot_d[1].pv = n_q;
            if (rd_next == NNULL) wt.tl = n_q;
            slot_d[2].v  = 1'b1;
            slot_d[2].m  = '{item: 1'b0, nxt: 1'b1, prv: 1'b0, flink: 1'b0};
            slot_d[2].a  = w_q.cur[NIW-1:0];
            slot_d[2].nx = n_q;
          end
          default: begin
            slot_d[0].nx = w_q.cur;
            slot_d[0].pv = rd_prev;
            slot_d[1].v  = (rd_prev != NNULL);
            slot_d[1].m  = '{item: 1'b0, nxt: 1'b1, prv: 1'b0, flink: 1'b0};
            slot_d[1].a  = rd_prev[NIW-1:0];
            slot_d[1].nx = n_q;
            if (rd_prev == NNULL) wt.hd = n_q;
            slot_d[2].v  = 1'b1;
            slot_d[2].m  = '{item: 1'b0, nxt: 1'b0, prv: 1'b1, flink: 1'b0};
            slot_d[2].a  = w_q.cur[NIW-1:0];
            slot_d[2].pv = n_q;
          end
        endcase
        wt.cur = n_q;
        wt.len = w_q.len + NW'(1);
        if (wt.len == NW'(1)) begin
          wt.bs = 1'b0;
          wt.be = 1'b0;
        end
        w_d     = wt;
        state_d = S_DRAIN;
      end

      S_STEP: begin
        nc      = (op_q == OP_PREV) ? rd_prev : rd_next;
        w_d.cur = nc;
        if (nc == NNULL) begin
          status_d = ST_EMPTY;
          state_d  = S_FINISH;
        end else begin
          rd_addr = nc[NIW-1:0];
          state_d = S_RDITEM;
        end
      end

      S_RDITEM: begin
        item_d   = rd_item;
        ivalid_d = 1'b1;
        state_d  = S_FINISH;
      end

      S_UNLINK: begin
        item_d   = rd_item;
        ivalid_d = 1'b1;
        p        = rd_prev;
        nc       = rd_next;
        slot_d[0].v  = (p != NNULL);
        slot_d[0].m  = '{item: 1'b0, nxt: 1'b1, prv: 1'b0, flink: 1'b0};
        slot_d[0].a  = p[NIW-1:0];
        slot_d[0].nx = nc;
        if (p == NNULL) wt.hd = nc;
        slot_d[1].v  = (nc != NNULL);
        slot_d[1].m  = '{item: 1'b0, nxt: 1'b0, prv: 1'b1, flink: 1'b0};
        slot_d[1].a  = nc[NIW-1:0];
        slot_d[1].pv = p;
        if (nc == NNULL) wt.tl = p;
        nlen   = (w_q.len != '0) ? (w_q.len - NW'(1)) : w_q.len;
        wt.len = nlen;
        if (op_q == OP_TRIM) begin
          wt.cur = wt.tl;
          wt.bs  = 1'b0;
          wt.be  = 1'b0;
        end else if (nlen == '0) begin
          wt.cur = NNULL;
        end else if (x_q == w_q.tl) begin
          wt.be  = 1'b1;
          wt.cur = NNULL;
        end else begin
          wt.cur = nc;
        end
        // Return the node to the free stack.
        slot_d[2].v  = 1'b1;
        slot_d[2].m  = '{item: 1'b0, nxt: 1'b0, prv: 1'b0, flink: 1'b1};
        slot_d[2].a  = x_q[NIW-1:0];
        slot_d[2].fl = ntop_q;
        ntop_d  = x_q;
        nodes_d = (nodes_q != '0) ? (nodes_q - NW'(1)) : nodes_q;
        w_d     = wt;
        state_d = S_DRAIN;
      end

      S_CAT: begin
        if (hrec.len != '0 && hrec.hd != NNULL) begin
          if (w_q.len != '0 && w_q.tl != NNULL) begin
            slot_d[0].v  = 1'b1;
            slot_d[0].m  = '{item: 1'b0, nxt: 1'b1, prv: 1'b0, flink: 1'b0};
            slot_d[0].a  = w_q.tl[NIW-1:0];
            slot_d[0].nx = hrec.hd;
            slot_d[1].v  = 1'b1;
            slot_d[1].m  = '{item: 1'b0, nxt: 1'b0, prv: 1'b1, flink: 1'b0};
            slot_d[1].a  = hrec.hd[NIW-1:0];
            slot_d[1].pv = w_q.tl;
            wt.tl  = hrec.tl;
            wt.len = w_q.len + hrec.len;
          end else begin
            wt.hd  = hrec.hd;
            wt.tl  = hrec.tl;
            wt.cur = NNULL;
            wt.bs  = 1'b1;
            wt.be  = 1'b0;
            wt.len = hrec.len;
          end
        end
        rel_en  = 1'b1;
        rel_id  = LIW'(s_q);
        w_d     = wt;
        state_d = S_DRAIN;
      end

      S_FREE: begin
        // The write port returns the current node; the next one is read.
        ntop_d  = x_q;
        nodes_d = (nodes_q != '0) ? (nodes_q - NW'(1)) : nodes_q;
        cnt_d   = cnt_q + NW'(1);
        if ((cnt_d < w_q.len) && rd_next != NNULL) begin
          x_d     = rd_next;
          rd_addr = rd_next[NIW-1:0];
        end else begin
          rel_en  = 1'b1;
          w_d     = HEAD_CLR;
          state_d = S_FINISH;
        end
      end

      S_SEARCH: begin
        if (rd_item == val_q) begin
          w_d.cur  = x_q;
          ivalid_d = 1'b1;
          item_d   = rd_item;
          state_d  = S_FINISH;
        end else if (rd_next == NNULL) begin
          w_d.cur  = NNULL;
          w_d.be   = 1'b1;
          status_d = ST_EMPTY;
          state_d  = S_FINISH;
        end else begin
          x_d     = rd_next;
          rd_addr = rd_next[NIW-1:0];
        end
      end

      S_DRAIN: begin
        dptr_d = dptr_q + 2'd1;
        if (dptr_q == 2'd2) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status      = status_q;
          out_d.item_valid  = ivalid_q;
          out_d.item_out    = ivalid_q ? 32'(item_q) : 32'd0;
          out_d.new_list_id = newid_q;
          out_d.list_length = 9'(w_q.len);
          out_valid_d       = 1'b1;
          wb_en             = wb_q;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ntop_q      <= '0;
      hwm_q       <= '0;
      nodes_q     <= '0;
      out_valid_q <= 1'b0;
      dptr_q      <= '0;
      wb_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      ntop_q      <= ntop_d;
      hwm_q       <= hwm_d;
      nodes_q     <= nodes_d;
      out_valid_q <= out_valid_d;
      dptr_q      <= dptr_d;
      wb_q        <= wb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    l_q      <= l_d;
    s_q      <= s_d;
    val_q    <= val_d;
    w_q      <= w_d;
    cat_q    <= cat_d;
    x_q      <= x_d;
    cnt_q    <= cnt_d;
    n_q      <= n_d;
    status_q <= status_d;
    ivalid_q <= ivalid_d;
    item_q   <= item_d;
    newid_q  <= newid_d;
    slot_q   <= slot_d;
    out_q    <= out_d;
  end

  // Head table, in-use bits and free head stack.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        heads_q[i]  <= HEAD_CLR;
        hflink_q[i] <= LW'(i + 1);
      end
      inuse_q <= '0;
      htop_q  <= '0;
      hcnt_q  <= '0;
    end else begin
      if (cr_en) begin
        heads_q[htop_q[LIW-1:0]]  <= HEAD_CLR;
        inuse_q[htop_q[LIW-1:0]]  <= 1'b1;
        hflink_q[htop_q[LIW-1:0]] <= HNULL;
        htop_q                    <= hflink_q[htop_q[LIW-1:0]];
        hcnt_q                    <= hcnt_q + LW'(1);
      end
      if (rel_en) begin
        heads_q[rel_id]  <= HEAD_CLR;
        inuse_q[rel_id]  <= 1'b0;
        hflink_q[rel_id] <= htop_q;
        htop_q           <= LW'(rel_id);
        if (hcnt_q != '0) hcnt_q <= hcnt_q - LW'(1);
      end
      if (wb_en) begin
        heads_q[LIW'(l_q)] <= w_q;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/llpm_checker.sv
// Port-level checks of the linked list pool manager, bound to the top level.
// Depends on llpm_pkg and linked_list_pool_manager_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "linked_list_pool_manager_defines.svh"

module llpm_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_i,
  input wire logic           out_valid_i,
  input wire logic           out_stall_i,
  input wire llpm_pkg::out_t out_data_i
);
  import llpm_pkg::*;

  // One request at a time: a transfer in closes the input for the next cycle.
  `LLPM_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_i, in_stall_i)
  // A stalled response stays put.
  `LLPM_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i,
                    out_valid_i && $stable(out_data_i))
  // An item is only returned with a good status.
  `LLPM_ASSERT_IMPL(a_item_ok, out_valid_i && out_data_i.item_valid,
                    out_data_i.status == ST_OK)
  // A null return carries a zero item.
  `LLPM_ASSERT_IMPL(a_null_zero, out_valid_i && !out_data_i.item_valid,
                    out_data_i.item_out == 32'd0)

endmodule

bind linked_list_pool_manager llpm_checker u_llpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire
